// ===== design/jd2g_pkg.sv =====
package jd2g_pkg;

  // field widths
  localparam int IN_W    = 47;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // default fixed point split of the input
  localparam int FRAC_BITS_DEF = 24;

  // calendar constants of the day number conversion
  localparam int unsigned DN_OFFSET = 68569;
  localparam int unsigned DIV_C     = 146097;
  localparam int unsigned YQ_MUL    = 4000;
  localparam int unsigned DIV_YQ    = 1461001;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned A2_OFFSET = 31;
  localparam int unsigned MI_MUL    = 80;
  localparam int unsigned DIV_MI    = 2447;
  localparam int unsigned DAY_ROUND = 79;
  localparam int unsigned MI_WRAP   = 11;
  localparam int unsigned MONTHS    = 12;
  localparam int unsigned YEAR_MUL  = 100;
  localparam int unsigned YEAR_BASE = 4900;

  // ceil(r / 80) is ((r + 79) >> 4) / 5, and x / 5 is (x * 205) >> 10 below 1024
  localparam int unsigned RECIP5       = 205;
  localparam int unsigned RECIP5_SHIFT = 10;

  // time of day constants
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned HOURS_PER_DAY = 24;

  // internal widths that follow from the fixed calendar ranges
  localparam int SOD_W = 17;                          // seconds of day, up to 86400
  localparam int R1_W  = $clog2(DIV_C);               // remainder of the century step
  localparam int A1_W  = R1_W - 2;                    // day within a 400 year block part
  localparam int X2_W  = 28;                          // 4000 * (a1 + 1)
  localparam int Q2_W  = $clog2(((64'd1 << X2_W) / DIV_YQ) + 1);
  localparam int R2_W  = $clog2(DIV_YQ);
  localparam int P_W   = 19;                          // 1461 * yq
  localparam int A2_W  = 10;                          // day of year from March plus 31
  localparam int X3_W  = 17;                          // 80 * a2
  localparam int Q3_W  = $clog2(((64'd1 << X3_W) / DIV_MI) + 1);
  localparam int R3_W  = $clog2(DIV_MI);
  localparam int QH_W  = $clog2(((64'd1 << SOD_W) / SEC_PER_HOUR) + 1);
  localparam int RH_W  = $clog2(SEC_PER_HOUR);
  localparam int QM_W  = $clog2(((64'd1 << RH_W) / SEC_PER_MIN) + 1);
  localparam int RM_W  = $clog2(SEC_PER_MIN);

  // load enables of the two register stages of a constant divider
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } div_en_t;

  typedef struct packed {
    logic [IN_W-1:0] julian_date;
  } sample_t;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
  } result_t;

endpackage

// ===== design/jd2g_chan_if.sv =====
interface jd2g_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/jd2g_cdiv.sv =====
module jd2g_cdiv #(
  parameter int          XW      = 20,
  parameter int          QW      = 3,
  parameter int          RW      = 18,
  parameter int unsigned DIVISOR = 146097
) (
  input  logic                clk,
  input  jd2g_pkg::div_en_t   en,
  input  logic [XW-1:0]       x,
  output logic [QW-1:0]       q,
  output logic [RW-1:0]       r
);

  // reciprocal scaled by 2^XW, rounded down: estimate is low by at most one
  localparam longint unsigned M = (64'd1 << XW) / DIVISOR;
  localparam int PW  = XW + QW;
  localparam int RW1 = RW + 1;

  logic [XW-1:0]  x_a_r;
  logic [PW-1:0]  p_a_r;
  logic [QW-1:0]  q0_b_r;
  logic [RW1-1:0] r0_b_r;
  logic [QW-1:0]  q0_nxt;
  logic [RW1-1:0] r0_nxt;
  logic [XW-1:0]  qd;
  logic [XW-1:0]  diff;

  // stage a: multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (en.ld_a) begin
      x_a_r <= x;
      p_a_r <= PW'(x) * PW'(M);
    end
  end

  // stage b: estimate and its remainder, which stays below twice the divisor
  always_comb begin
    q0_nxt = p_a_r[PW-1:XW];
    qd     = XW'(q0_nxt) * XW'(DIVISOR);
    diff   = x_a_r - qd;
    r0_nxt = diff[RW1-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.ld_b) begin
      q0_b_r <= q0_nxt;
      r0_b_r <= r0_nxt;
    end
  end

  // one correction step
  always_comb begin
    if (r0_b_r >= RW1'(DIVISOR)) begin
      q = q0_b_r + QW'(1);
      r = RW'(r0_b_r - RW1'(DIVISOR));
    end else begin
      q = q0_b_r;
      r = r0_b_r[RW-1:0];
    end
  end

endmodule

// ===== design/julian_date_to_gregorian.sv =====
// Converts a Julian date in unsigned fixed point (FRAC_BITS fraction bits in a 47-bit word)
// into a proleptic Gregorian year, month and day plus hour, minute and second rounded to
// the nearest second. Half a day is added first, so the day changes at midnight. The block
// is a 12-stage pipeline that takes one transfer per cycle while the output is ready or a
// stage is empty; every constant division is a reciprocal multiply with one correction
// spread over two stages, and those multiplier stages set the depth. Each stage has its own
// valid bit and a stage loads whenever it is empty or the stage after it moves, so bubbles
// are squeezed out and the input keeps flowing while a result waits at the output register.
// A fraction that rounds up to a full day reads as 00:00:00 of the same date; the date does
// not move to the next day.
module julian_date_to_gregorian #(
  parameter int FRAC_BITS = jd2g_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  jd2g_chan_if.sink   in_ch,
  jd2g_chan_if.source out_ch
);

  localparam int NS    = 12;
  localparam int T_W   = jd2g_pkg::IN_W + 1;
  localparam int DN_W  = T_W - FRAC_BITS;
  localparam int A_W   = ((DN_W > 17) ? DN_W : 17) + 1;
  localparam int X1_W  = A_W + 2;
  localparam int Q1_W  = $clog2(((64'd1 << X1_W) / jd2g_pkg::DIV_C) + 1);
  localparam int PS_W  = FRAC_BITS + jd2g_pkg::SOD_W;
  localparam int CR_LO = 5;
  localparam int CR_HI = NS - 2;
  localparam logic [NS-1:0] ONES = {NS{1'b1}};
  localparam logic [T_W-1:0]  HALF_T = T_W'(1) << (FRAC_BITS - 1);
  localparam logic [PS_W-1:0] HALF_S = PS_W'(1) << (FRAC_BITS - 1);

  // values that ride along from the sixth stage to the output
  typedef struct packed {
    logic [jd2g_pkg::YEAR_W-1:0] yc;
    logic [jd2g_pkg::Q2_W-1:0]   yq;
    logic [jd2g_pkg::HOUR_W-1:0] hour;
    logic [jd2g_pkg::MIN_W-1:0]  minute;
    logic [jd2g_pkg::SEC_W-1:0]  second;
  } carry_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;

  logic [T_W-1:0]       t_sum;
  logic [DN_W-1:0]      dn_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [A_W-1:0]       a_sum;
  logic [X1_W-1:0]      x1_r;
  logic [PS_W-1:0]      ps_r;
  logic [PS_W-1:0]      ps_round;
  logic [jd2g_pkg::SOD_W-1:0] secs_r;

  logic [Q1_W-1:0]           c_div;
  logic [jd2g_pkg::R1_W-1:0] r1_div;
  logic [Q1_W-1:0]           c_r;
  logic [jd2g_pkg::A1_W-1:0] a1_nxt;
  logic [jd2g_pkg::A1_W-1:0] a1_r [4:7];
  logic [jd2g_pkg::X2_W-1:0] x2_r;

  logic [jd2g_pkg::QH_W-1:0] qh_div;
  logic [jd2g_pkg::RH_W-1:0] rh_div;
  logic [jd2g_pkg::RH_W-1:0] rh_r;
  logic [jd2g_pkg::QM_W-1:0] qm_div;
  logic [jd2g_pkg::RM_W-1:0] rm_div;

  logic [jd2g_pkg::Q2_W-1:0] yq_div;
  logic [jd2g_pkg::P_W-1:0]  p7_r;
  logic [16:0]               a2_full;
  logic [jd2g_pkg::A2_W-1:0] a2;
  logic [jd2g_pkg::X3_W-1:0] x3_r;

  logic [jd2g_pkg::Q3_W-1:0] mi_div;
  logic [jd2g_pkg::R3_W-1:0] r3_div;
  logic [jd2g_pkg::R3_W-1:0] dy_t;
  logic [15:0]               dy_p;
  logic                      ym;
  logic [jd2g_pkg::Q3_W-1:0] mo_w;

  carry_t cr_r   [CR_LO:CR_HI];
  carry_t cr_nxt [CR_LO:CR_HI];

  jd2g_pkg::result_t res_r;
  jd2g_pkg::result_t res_nxt;

  // stage i moves when it is empty or every full stage after it can drain
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      rdy[i] = out_ch.ready || ((v_r >> i) != (ONES >> i));
    end
  end

  assign v_nxt       = {v_r[NS-2:0], in_ch.valid};
  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  // stage 0: add half a day, split day number and fraction
  assign t_sum = T_W'(in_ch.data.julian_date) + HALF_T;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dn_r   <= t_sum[T_W-1:FRAC_BITS];
      frac_r <= t_sum[FRAC_BITS-1:0];
    end
  end

  // stage 1: offset day number, scale fraction to seconds
  assign a_sum = A_W'(dn_r) + A_W'(jd2g_pkg::DN_OFFSET);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x1_r <= {a_sum, 2'b00};
      ps_r <= PS_W'(frac_r) * PS_W'(jd2g_pkg::SEC_PER_DAY);
    end
  end

  // stage 2: round to whole seconds
  assign ps_round = ps_r + HALF_S;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      secs_r <= ps_round[PS_W-1:FRAC_BITS];
    end
  end

  // century count c = 4a / 146097, stages 2 and 3
  jd2g_cdiv #(
    .XW      (X1_W),
    .QW      (Q1_W),
    .RW      (jd2g_pkg::R1_W),
    .DIVISOR (jd2g_pkg::DIV_C)
  ) u_div_c (
    .clk (clk),
    .en  ({rdy[2], rdy[3]}),
    .x   (x1_r),
    .q   (c_div),
    .r   (r1_div)
  );

  // hours = seconds / 3600, stages 3 and 4
  jd2g_cdiv #(
    .XW      (jd2g_pkg::SOD_W),
    .QW      (jd2g_pkg::QH_W),
    .RW      (jd2g_pkg::RH_W),
    .DIVISOR (jd2g_pkg::SEC_PER_HOUR)
  ) u_div_hr (
    .clk (clk),
    .en  ({rdy[3], rdy[4]}),
    .x   (secs_r),
    .q   (qh_div),
    .r   (rh_div)
  );

  // stage 4: day within the century is the remainder over four
  assign a1_nxt = r1_div[jd2g_pkg::R1_W-1:2];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      c_r     <= c_div;
      x2_r    <= (jd2g_pkg::X2_W'(a1_nxt) + jd2g_pkg::X2_W'(1))
                 * jd2g_pkg::X2_W'(jd2g_pkg::YQ_MUL);
    end
  end

  // year within the century yq = 4000 (a1 + 1) / 1461001, stages 5 and 6
  jd2g_cdiv #(
    .XW      (jd2g_pkg::X2_W),
    .QW      (jd2g_pkg::Q2_W),
    .RW      (jd2g_pkg::R2_W),
    .DIVISOR (jd2g_pkg::DIV_YQ)
  ) u_div_yq (
    .clk (clk),
    .en  ({rdy[5], rdy[6]}),
    .x   (x2_r),
    .q   (yq_div),
    .r   ()
  );

  // minutes and seconds of the hour, stages 6 and 7
  jd2g_cdiv #(
    .XW      (jd2g_pkg::RH_W),
    .QW      (jd2g_pkg::QM_W),
    .RW      (jd2g_pkg::RM_W),
    .DIVISOR (jd2g_pkg::SEC_PER_MIN)
  ) u_div_mn (
    .clk (clk),
    .en  ({rdy[6], rdy[7]}),
    .x   (rh_r),
    .q   (qm_div),
    .r   (rm_div)
  );

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      rh_r <= rh_div;
    end
  end

  // carried fields, filled in as they become known
  always_comb begin
    cr_nxt[CR_LO]    = '0;
    cr_nxt[CR_LO].yc = jd2g_pkg::YEAR_W'(c_r) * jd2g_pkg::YEAR_W'(jd2g_pkg::YEAR_MUL)
                       - jd2g_pkg::YEAR_W'(jd2g_pkg::YEAR_BASE);
    // a full day of rounded seconds wraps to hour zero
    if (qh_div == jd2g_pkg::QH_W'(jd2g_pkg::HOURS_PER_DAY)) begin
      cr_nxt[CR_LO].hour = '0;
    end else begin
      cr_nxt[CR_LO].hour = qh_div[jd2g_pkg::HOUR_W-1:0];
    end
    for (int i = CR_LO + 1; i <= CR_HI; i++) begin
      cr_nxt[i] = cr_r[i-1];
    end
    cr_nxt[7].yq     = yq_div;
    cr_nxt[8].minute = qm_div[jd2g_pkg::MIN_W-1:0];
    cr_nxt[8].second = rm_div;
  end

  always_ff @(posedge clk) begin
    for (int i = CR_LO; i <= CR_HI; i++) begin
      if (rdy[i]) begin
        cr_r[i] <= cr_nxt[i];
      end
    end
  end

  // day within the century rides from stage 4 to stage 7
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      a1_r[4] <= a1_nxt;
    end
    for (int i = 5; i <= 7; i++) begin
      if (rdy[i]) begin
        a1_r[i] <= a1_r[i-1];
      end
    end
  end

  // stage 7: days taken by whole years of the century
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      p7_r <= jd2g_pkg::P_W'(yq_div) * jd2g_pkg::P_W'(jd2g_pkg::DAYS_4Y);
    end
  end

  // stage 8: day of the year counted from March, scaled for the month step
  always_comb begin
    a2_full = 17'(a1_r[7]) + 17'(jd2g_pkg::A2_OFFSET) - 17'(p7_r >> 2);
    a2      = a2_full[jd2g_pkg::A2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      x3_r <= jd2g_pkg::X3_W'(a2) * jd2g_pkg::X3_W'(jd2g_pkg::MI_MUL);
    end
  end

  // month index mi = 80 a2 / 2447, stages 9 and 10
  jd2g_cdiv #(
    .XW      (jd2g_pkg::X3_W),
    .QW      (jd2g_pkg::Q3_W),
    .RW      (jd2g_pkg::R3_W),
    .DIVISOR (jd2g_pkg::DIV_MI)
  ) u_div_mi (
    .clk (clk),
    .en  ({rdy[9], rdy[10]}),
    .x   (x3_r),
    .q   (mi_div),
    .r   (r3_div)
  );

  // stage 11: day is the remainder over 80 rounded up, then month and year
  always_comb begin
    dy_t = r3_div + jd2g_pkg::R3_W'(jd2g_pkg::DAY_ROUND);
    dy_p = 16'(dy_t[jd2g_pkg::R3_W-1:4]) * 16'(jd2g_pkg::RECIP5);
    ym   = (mi_div >= jd2g_pkg::Q3_W'(jd2g_pkg::MI_WRAP));
    mo_w = mi_div + jd2g_pkg::Q3_W'(2) - (ym ? jd2g_pkg::Q3_W'(jd2g_pkg::MONTHS) : '0);

    res_nxt.year   = cr_r[CR_HI].yc + jd2g_pkg::YEAR_W'(cr_r[CR_HI].yq)
                     + jd2g_pkg::YEAR_W'(ym);
    res_nxt.month  = mo_w[jd2g_pkg::MONTH_W-1:0];
    res_nxt.day    = dy_p[jd2g_pkg::RECIP5_SHIFT +: jd2g_pkg::DAY_W];
    res_nxt.hour   = cr_r[CR_HI].hour;
    res_nxt.minute = cr_r[CR_HI].minute;
    res_nxt.second = cr_r[CR_HI].second;
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = v_r[NS-1];
  assign out_ch.data  = res_r;

  // a result at the output either just arrived from the stage before or was held
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $past(v_r[NS-2]) || $past(out_ch.valid))
    else $error("output valid without an item in the stage before");

  // time of day fields stay in range, including the full day wrap
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.hour < 5'd24) && (out_ch.data.minute < 6'd60)
                     && (out_ch.data.second < 6'd60))
    else $error("time of day out of range");

  // every result has a month from 1 to 12 and a nonzero day
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.month != 4'd0) && (out_ch.data.month <= 4'd12)
                     && (out_ch.data.day != 5'd0))
    else $error("month or day out of range");

endmodule
